// ===== hw/rtl/cwc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwc_pkg
// Shared types and constants of the column weighted centroid block.
// ----------------------------------------------------------------------------
package cwc_pkg;

  localparam int PIX_W  = 8;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 10;
  localparam int CENT_W = 17;
  localparam int THR_W  = 8;
  localparam int RC_W   = 11;
  // Wide enough for the clamped row count (largest allowed frame height).
  localparam int RCX_W  = 13;
  localparam int WSUM_W = 29;
  localparam int VSUM_W = 18;
  localparam int PROD_W = (ROW_W + 1) + PIX_W;
  localparam int NUM_W  = WSUM_W + 6;
  localparam int QUO_STEPS = CENT_W;
  localparam int CNT_W  = 5;

  localparam logic [THR_W-1:0]  THRESHOLD_RST = THR_W'(150);
  localparam logic [RC_W-1:0]   ROW_COUNT_RST = RC_W'(700);
  localparam logic [CENT_W-1:0] Q6_ONE = CENT_W'(64);
  localparam logic [CENT_W-1:0] Q6_MAX = CENT_W'(65536);

  typedef enum logic {
    REG_THRESHOLD,
    REG_ROW_COUNT
  } reg_idx_e;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_DONE
  } div_state_e;

  typedef struct packed {
    logic [WSUM_W-1:0] wsum;
    logic [VSUM_W-1:0] vsum;
  } sums_t;

  typedef struct packed {
    logic [COL_W-1:0]  col;
    logic [WSUM_W-1:0] num;
    logic [VSUM_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic [COL_W-1:0]  col;
    logic [CENT_W-1:0] centroid;
    logic              found;
  } div_res_t;

endpackage

// ===== hw/rtl/cwc_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwc_if
// Valid/ready channels for pixel beats and centroid result beats.
// ----------------------------------------------------------------------------
interface cwc_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel;
  logic [6:0] column;
  logic [9:0] row;

  modport source (output valid, output pixel, output column, output row, input ready);
  modport sink   (input valid, input pixel, input column, input row, output ready);
endinterface

interface cwc_res_if;
  logic        valid;
  logic        ready;
  logic [6:0]  out_column;
  logic [16:0] centroid_q6;
  logic        found;

  modport source (output valid, output out_column, output centroid_q6, output found,
                  input ready);
  modport sink   (input valid, input out_column, input centroid_q6, input found,
                  output ready);
endinterface

// ===== hw/rtl/cwc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module cwc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/cwc_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwc_div
// Restoring divider for the Q6 centroid, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cwc_div
  import cwc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  div_req_t req_i,
  output logic     busy_o,
  output logic     res_valid_o,
  input  logic     res_ready_i,
  output div_res_t res_o
);

  div_state_e state_q, state_d;

  logic [VSUM_W-1:0] rem_q, rem_d;
  logic [CENT_W-1:0] numlo_q, numlo_d;
  logic [CENT_W-1:0] quo_q, quo_d;
  logic [VSUM_W-1:0] den_q, den_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic              found_q, found_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;

  logic [NUM_W-1:0]  numer;
  logic              den_zero;
  logic              overflow;
  logic [VSUM_W:0]   rem_sh;
  logic [VSUM_W:0]   rem_diff;
  logic              rem_ge;
  logic              last_step;

  // Rounded numerator: sum * 64 + den / 2.
  assign numer    = {req_i.num, 6'b0} + NUM_W'(req_i.den[VSUM_W-1:1]);
  assign den_zero = (req_i.den == '0);
  // The quotient would not fit in the result width, so it clamps anyway.
  assign overflow = (numer[NUM_W-1:CENT_W] >= req_i.den);

  assign rem_sh    = {rem_q, numlo_q[CENT_W-1]};
  assign rem_diff  = rem_sh - {1'b0, den_q};
  assign rem_ge    = (rem_sh >= {1'b0, den_q});
  assign last_step = (cnt_q == CNT_W'(QUO_STEPS - 1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      DIV_IDLE: begin
        if (start_i) begin
          state_d = (den_zero || overflow) ? DIV_DONE : DIV_RUN;
        end
      end
      DIV_RUN: begin
        if (last_step) begin
          state_d = DIV_DONE;
        end
      end
      DIV_DONE: begin
        if (res_ready_i) begin
          state_d = DIV_IDLE;
        end
      end
      default: state_d = DIV_IDLE;
    endcase
  end

  always_comb begin
    rem_d   = rem_q;
    numlo_d = numlo_q;
    quo_d   = quo_q;
    den_d   = den_q;
    col_d   = col_q;
    found_d = found_q;
    cnt_d   = cnt_q;
    if (state_q == DIV_IDLE && start_i) begin
      rem_d   = numer[NUM_W-1:CENT_W];
      numlo_d = numer[CENT_W-1:0];
      den_d   = req_i.den;
      col_d   = req_i.col;
      found_d = !den_zero;
      cnt_d   = '0;
      if (den_zero) begin
        quo_d = Q6_ONE;
      end else if (overflow) begin
        quo_d = Q6_MAX;
      end else begin
        quo_d = '0;
      end
    end else if (state_q == DIV_RUN) begin
      rem_d   = rem_ge ? rem_diff[VSUM_W-1:0] : rem_sh[VSUM_W-1:0];
      numlo_d = {numlo_q[CENT_W-2:0], 1'b0};
      quo_d   = {quo_q[CENT_W-2:0], rem_ge};
      cnt_d   = cnt_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DIV_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q   <= rem_d;
    numlo_q <= numlo_d;
    quo_q   <= quo_d;
    den_q   <= den_d;
    col_q   <= col_d;
    found_q <= found_d;
    cnt_q   <= cnt_d;
  end

  always_comb begin
    busy_o         = (state_q != DIV_IDLE);
    res_valid_o    = (state_q == DIV_DONE);
    res_o.col      = col_q;
    res_o.found    = found_q;
    if (quo_q < Q6_ONE) begin
      res_o.centroid = Q6_ONE;
    end else if (quo_q > Q6_MAX) begin
      res_o.centroid = Q6_MAX;
    end else begin
      res_o.centroid = quo_q;
    end
  end

endmodule

// ===== hw/rtl/column_weighted_centroid.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// column_weighted_centroid
// Per-column intensity-weighted row centroid of a thresholded pixel stream.
// ----------------------------------------------------------------------------
//  Port     Dir  Beat contents
//  pix_i    in   pixel, column, row
//  res_o    out  out_column, centroid_q6, found
//  APB      in   register writes/reads (threshold at 0x0, row_count at 0x4)
//
//  A pixel beat is taken every cycle unless input is blocked; the column sums
//  live in one RAM with a registered read, updated the next cycle, with the
//  last write forwarded. A pixel on the last row blocks input until the
//  divider, producing one quotient bit per cycle, has finished and its result
//  is taken; an empty column or an overflowing quotient skips the division.
//  After reset the RAM is cleared one column per cycle, all COLUMNS columns,
//  with no pixel beat taken; register writes are taken throughout.
//  A stalled result beat does not block input until the divider is needed.
// ----------------------------------------------------------------------------
module column_weighted_centroid
  import cwc_pkg::*;
#(
  parameter int COLUMNS  = 128,
  parameter int MAX_ROWS = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  cwc_pix_if.sink     pix_i,
  cwc_res_if.source   res_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

  // Configuration registers.
  logic [THR_W-1:0] thr_q;
  logic [RC_W-1:0]  rc_q;
  reg_idx_e         reg_idx;
  logic             cfg_we;

  assign reg_idx = reg_idx_e'(paddr[2]);
  assign cfg_we  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THRESHOLD_RST;
      rc_q  <= ROW_COUNT_RST;
    end else if (cfg_we) begin
      case (reg_idx)
        REG_THRESHOLD: thr_q <= pwdata[THR_W-1:0];
        REG_ROW_COUNT: rc_q  <= pwdata[RC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_THRESHOLD: prdata = 32'(thr_q);
      REG_ROW_COUNT: prdata = 32'(rc_q);
      default:       prdata = '0;
    endcase
  end

  // Clearing pass after reset.
  logic          clear_q;
  logic [AW-1:0] clr_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_q    <= 1'b1;
      clr_addr_q <= '0;
    end else if (clear_q) begin
      clr_addr_q <= clr_addr_q + AW'(1);
      if (clr_addr_q == AW'(COLUMNS - 1)) begin
        clear_q <= 1'b0;
      end
    end
  end

  // Input decode.
  logic [RCX_W-1:0] rc_ext;
  logic [RCX_W-1:0] rows_eff;
  logic [ROW_W:0]   row_p1;
  logic             in_col_ok;
  logic             in_row_ok;
  logic             in_last;
  logic [PIX_W-1:0] kept;
  logic             accept;
  logic             div_busy;

  logic             s1_valid_q;
  logic             s1_last_q;
  logic [AW-1:0]    s1_addr_q;
  logic [COL_W-1:0] s1_col_q;
  logic [PROD_W-1:0] s1_prod_q;
  logic [PIX_W-1:0] s1_kept_q;

  assign rc_ext   = RCX_W'(rc_q);
  assign rows_eff = (rc_q == '0) ? RCX_W'(1) :
                    (rc_ext > RCX_W'(MAX_ROWS)) ? RCX_W'(MAX_ROWS) : rc_ext;
  assign row_p1    = (ROW_W + 1)'(pix_i.row) + (ROW_W + 1)'(1);
  assign in_col_ok = (32'(pix_i.column) < 32'(COLUMNS));
  assign in_row_ok = (RCX_W'(pix_i.row) < rows_eff);
  assign in_last   = (RCX_W'(row_p1) == rows_eff);
  assign kept      = (pix_i.pixel > thr_q) ? pix_i.pixel : '0;

  assign pix_i.ready = !clear_q && !div_busy && !(s1_valid_q && s1_last_q);
  assign accept      = pix_i.valid && pix_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept && in_col_ok && in_row_ok;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_last_q <= in_last;
      s1_addr_q <= AW'(pix_i.column);
      s1_col_q  <= pix_i.column;
      s1_prod_q <= PROD_W'(row_p1) * PROD_W'(kept);
      s1_kept_q <= kept;
    end
  end

  // Column sums RAM and read-modify-write.
  sums_t         ram_rdata;
  sums_t         ram_wdata;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;

  logic          fwd_valid_q;
  logic [AW-1:0] fwd_addr_q;
  sums_t         fwd_data_q;

  sums_t             base;
  sums_t             upd;
  logic [WSUM_W:0]   wsum_ext;
  logic [VSUM_W:0]   vsum_ext;
  logic              s1_we;

  cwc_ram #(
    .WIDTH($bits(sums_t)),
    .DEPTH(COLUMNS)
  ) u_sums_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(AW'(pix_i.column)),
    .rdata_o(ram_rdata)
  );

  // The write of the previous item lands in the same edge as this item's
  // read, so that value comes from the forward register instead.
  assign base = (fwd_valid_q && (fwd_addr_q == s1_addr_q)) ? fwd_data_q : ram_rdata;

  assign wsum_ext = {1'b0, base.wsum} + (WSUM_W + 1)'(s1_prod_q);
  assign vsum_ext = {1'b0, base.vsum} + (VSUM_W + 1)'(s1_kept_q);

  always_comb begin
    upd.wsum = wsum_ext[WSUM_W] ? '1 : wsum_ext[WSUM_W-1:0];
    upd.vsum = vsum_ext[VSUM_W] ? '1 : vsum_ext[VSUM_W-1:0];
  end

  assign s1_we     = s1_valid_q;
  assign ram_we    = clear_q || s1_we;
  assign ram_waddr = clear_q ? clr_addr_q : s1_addr_q;
  assign ram_wdata = (clear_q || s1_last_q) ? '0 : upd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_valid_q <= 1'b0;
    end else if (s1_we) begin
      fwd_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_we) begin
      fwd_addr_q <= s1_addr_q;
      fwd_data_q <= ram_wdata;
    end
  end

  // Centroid divider and result register.
  div_req_t div_req;
  div_res_t div_res;
  logic     div_start;
  logic     div_res_valid;
  logic     div_res_ready;

  logic              out_valid_q;
  logic [COL_W-1:0]  out_col_q;
  logic [CENT_W-1:0] out_cent_q;
  logic              out_found_q;

  assign div_start    = s1_valid_q && s1_last_q;
  assign div_req.col  = s1_col_q;
  assign div_req.num  = upd.wsum;
  assign div_req.den  = upd.vsum;
  assign div_res_ready = !out_valid_q || res_o.ready;

  cwc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .req_i      (div_req),
    .busy_o     (div_busy),
    .res_valid_o(div_res_valid),
    .res_ready_i(div_res_ready),
    .res_o      (div_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (div_res_ready) begin
      out_valid_q <= div_res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_res_ready && div_res_valid) begin
      out_col_q   <= div_res.col;
      out_cent_q  <= div_res.centroid;
      out_found_q <= div_res.found;
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.out_column  = out_col_q;
  assign res_o.centroid_q6 = out_cent_q;
  assign res_o.found       = out_found_q;

`ifndef SYNTHESIS
  // A last-row pixel always hands its sums to the divider on the next edge.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_last_q) |=> div_busy)
    else $error("last-row pixel did not start the divider");

  // No sum update may race the clearing pass.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear_q |-> !s1_valid_q)
    else $error("column update during clearing pass");

  // While dividing, no second last-row pixel can be waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy |-> !(s1_valid_q && s1_last_q))
    else $error("last-row pixel pending while divider busy");
`endif

endmodule
